/* hw/rtl/rhd_pkg.sv */
// ----------------------------------------------------------------------------
// rhd_pkg
// Shared constants and types for the RGB 2x2 half-size downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package rhd_pkg;

    // Largest supported frame
    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    // Line store holds one pair sum per horizontal pixel pair
    localparam int LINE_DEPTH = MAX_WIDTH / 2;

    // Field widths
    localparam int DIM_W     = 12;                  // config register width
    localparam int COL_W     = $clog2(MAX_WIDTH);   // column counter
    localparam int ROW_W     = $clog2(MAX_HEIGHT);  // row counter
    localparam int IDX_W     = $clog2(LINE_DEPTH);  // line store address
    localparam int CHAN_W    = 8;                   // one color channel
    localparam int PSUM_W    = CHAN_W + 1;          // sum of two channels
    localparam int QSUM_W    = CHAN_W + 2;          // sum of four channels
    localparam int CFG_IDX_W = 1;

    // Clamp bounds as register-wide values
    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);
    localparam logic [DIM_W-1:0] RESET_W   = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_H   = DIM_W'(480);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 1'b0,
        CFG_IMAGE_HEIGHT = 1'b1
    } rhd_cfg_idx_t;

    // Three pair sums packed red, green, blue
    typedef struct packed {
        logic [PSUM_W-1:0] r;
        logic [PSUM_W-1:0] g;
        logic [PSUM_W-1:0] b;
    } rhd_psum_t;

    // Raster position of the pixel being transferred
    typedef struct packed {
        logic             pair_active;  // inside the full column pairs and row pairs
        logic             odd_col;
        logic             odd_row;
        logic [IDX_W-1:0] line_idx;
        logic             row_end;
        logic             frame_end;
    } rhd_pos_t;

endpackage : rhd_pkg

`default_nettype wire

/* hw/rtl/rhd_raster_ctrl.sv */
// ----------------------------------------------------------------------------
// rhd_raster_ctrl
// Frame size registers and column/row counters; classifies each pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module rhd_raster_ctrl (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rhd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rhd_pkg::DIM_W-1:0]      cfg_data,
    input  wire logic                           step,
    output rhd_pkg::rhd_pos_t                   pos
);
    import rhd_pkg::*;

    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;

    logic [DIM_W-1:0] eff_w;
    logic [DIM_W-1:0] eff_h;
    logic [DIM_W-1:0] pair_cols;
    logic [DIM_W-1:0] pair_rows;
    logic [DIM_W-1:0] col_inc;
    logic [DIM_W-1:0] row_inc;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= RESET_W;
            height_reg <= RESET_H;
        end
        else if (cfg_we)
        begin
            unique case (rhd_cfg_idx_t'(cfg_index))
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Effective size clamped to 1..max, rounded down to full pairs
    always_comb
    begin
        if (width_reg == '0)
            eff_w = DIM_W'(1);
        else if (width_reg > MAX_W_DIM)
            eff_w = MAX_W_DIM;
        else
            eff_w = width_reg;

        if (height_reg == '0)
            eff_h = DIM_W'(1);
        else if (height_reg > MAX_H_DIM)
            eff_h = MAX_H_DIM;
        else
            eff_h = height_reg;

        pair_cols = {eff_w[DIM_W-1:1], 1'b0};
        pair_rows = {eff_h[DIM_W-1:1], 1'b0};
        col_inc   = DIM_W'(col_reg) + DIM_W'(1);
        row_inc   = DIM_W'(row_reg) + DIM_W'(1);
    end

    // Pixel classification
    always_comb
    begin
        pos.pair_active = (DIM_W'(col_reg) < pair_cols) && (DIM_W'(row_reg) < pair_rows);
        pos.odd_col     = col_reg[0];
        pos.odd_row     = row_reg[0];
        pos.line_idx    = col_reg[COL_W-1:1];
        pos.row_end     = (col_inc == pair_cols);
        pos.frame_end   = (col_inc == pair_cols) && (row_inc == pair_rows);
    end

    // Counter advance with row and frame wrap
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_inc >= eff_w)
        begin
            col_next = '0;
            if (row_inc >= eff_h)
                row_next = '0;
            else
                row_next = row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (step)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule : rhd_raster_ctrl

`default_nettype wire

/* hw/rtl/rgb_half_downscale_top.sv */
// ----------------------------------------------------------------------------
// rgb_half_downscale_top
// 2x2 box-filter downscaler for a raster stream of RGB888 pixels.
//
//   channel | signals                                  | direction
//   --------+------------------------------------------+----------
//   config  | cfg_we, cfg_index, cfg_data              | in
//   pixel   | in_valid/in_ready, red/green/blue_in     | in
//   result  | out_valid/out_ready, *_avg, row/frame_end| out
//
// One pixel transfer per clock while in_ready is high. The line store read
// and the pair sum are registered at the transfer of the pixel that
// completes a block; the four-pixel sum goes into the output register
// once that register is free, and the result is presented from there.
// Reset clears the counters and the pipeline; the size registers return
// to 640x480. The line store is not cleared.
// A stalled result holds the output register; the middle stage keeps
// taking pixels until it is also full.
// ----------------------------------------------------------------------------
`default_nettype none

module rgb_half_downscale_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [rhd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [rhd_pkg::DIM_W-1:0]      cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rhd_pkg::CHAN_W-1:0]     red_in,
    input  wire logic [rhd_pkg::CHAN_W-1:0]     green_in,
    input  wire logic [rhd_pkg::CHAN_W-1:0]     blue_in,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [rhd_pkg::CHAN_W-1:0]          red_avg,
    output logic [rhd_pkg::CHAN_W-1:0]          green_avg,
    output logic [rhd_pkg::CHAN_W-1:0]          blue_avg,
    output logic                                row_end,
    output logic                                frame_end
);
    import rhd_pkg::*;

    rhd_pos_t          pos;
    logic              xfer;
    logic              out_free;
    logic              s1_free;
    logic              s1_move;

    logic [3*CHAN_W-1:0] first_pixel_reg;
    rhd_psum_t           psum;
    rhd_psum_t           line_mem [LINE_DEPTH];
    rhd_psum_t           above_reg;

    logic                s1_valid_reg;
    rhd_psum_t           s1_sum_reg;
    logic                s1_row_end_reg;
    logic                s1_frame_end_reg;

    logic [QSUM_W-1:0]   tot_r;
    logic [QSUM_W-1:0]   tot_g;
    logic [QSUM_W-1:0]   tot_b;

    logic                out_valid_reg;
    logic [CHAN_W-1:0]   red_reg;
    logic [CHAN_W-1:0]   green_reg;
    logic [CHAN_W-1:0]   blue_reg;
    logic                row_end_reg;
    logic                frame_end_reg;

    // Position tracking
    rhd_raster_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .step      (xfer),
        .pos       (pos)
    );

    // Handshake
    assign out_free = !out_valid_reg || out_ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign s1_move  = s1_valid_reg && out_free;
    assign in_ready = s1_free;
    assign xfer     = in_valid && in_ready;

    // First pixel of each horizontal pair
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            first_pixel_reg <= '0;
        else if (xfer && pos.pair_active && !pos.odd_col)
            first_pixel_reg <= {red_in, green_in, blue_in};
    end

    // Horizontal pair sum
    always_comb
    begin
        psum.r = {1'b0, red_in}   + {1'b0, first_pixel_reg[3*CHAN_W-1:2*CHAN_W]};
        psum.g = {1'b0, green_in} + {1'b0, first_pixel_reg[2*CHAN_W-1:CHAN_W]};
        psum.b = {1'b0, blue_in}  + {1'b0, first_pixel_reg[CHAN_W-1:0]};
    end

    // Line store: even rows write pair sums, odd rows read them back
    always_ff @(posedge clk)
    begin
        if (xfer && pos.pair_active && pos.odd_col && !pos.odd_row)
            line_mem[pos.line_idx] <= psum;
    end

    always_ff @(posedge clk)
    begin
        if (xfer && pos.pair_active && pos.odd_col && pos.odd_row)
            above_reg <= line_mem[pos.line_idx];
    end

    // Middle stage: pair sum and flags of a completed block
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (xfer)
            s1_valid_reg <= pos.pair_active && pos.odd_col && pos.odd_row;
        else if (s1_move)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            s1_sum_reg       <= psum;
            s1_row_end_reg   <= pos.row_end;
            s1_frame_end_reg <= pos.frame_end;
        end
    end

    // Four-pixel sum
    always_comb
    begin
        tot_r = {1'b0, s1_sum_reg.r} + {1'b0, above_reg.r};
        tot_g = {1'b0, s1_sum_reg.g} + {1'b0, above_reg.g};
        tot_b = {1'b0, s1_sum_reg.b} + {1'b0, above_reg.b};
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            red_reg       <= tot_r[QSUM_W-1:2];
            green_reg     <= tot_g[QSUM_W-1:2];
            blue_reg      <= tot_b[QSUM_W-1:2];
            row_end_reg   <= s1_row_end_reg;
            frame_end_reg <= s1_frame_end_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign red_avg   = red_reg;
    assign green_avg = green_reg;
    assign blue_avg  = blue_reg;
    assign row_end   = row_end_reg;
    assign frame_end = frame_end_reg;

endmodule : rgb_half_downscale_top

`default_nettype wire

/* hw/rtl/rhd_checker.sv */
// ----------------------------------------------------------------------------
// rhd_checker
// Port-level checks for the downscaler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rhd_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_ready,
    input wire logic                        out_valid,
    input wire logic                        out_ready,
    input wire logic [rhd_pkg::CHAN_W-1:0]  red_avg,
    input wire logic [rhd_pkg::CHAN_W-1:0]  green_avg,
    input wire logic [rhd_pkg::CHAN_W-1:0]  blue_avg,
    input wire logic                        row_end,
    input wire logic                        frame_end
);
    import rhd_pkg::*;

    // Stalled result holds until its transfer
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(red_avg)
            && $stable(green_avg) && $stable(blue_avg)
            && $stable(row_end) && $stable(frame_end))
        else $error("result changed while stalled");

    // End of frame is always also end of row
    a_frame_row: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_end |-> row_end)
        else $error("frame_end without row_end");

    // Empty output register never blocks the input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // A taken output register frees the input in the next cycle unless a new result moves in
    a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready || out_valid)
        else $error("input stalled after result transfer");

endmodule : rhd_checker

bind rgb_half_downscale_top rhd_checker u_rhd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .red_avg   (red_avg),
    .green_avg (green_avg),
    .blue_avg  (blue_avg),
    .row_end   (row_end),
    .frame_end (frame_end)
);

`default_nettype wire

/* tb/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for rgb_half_downscale_top.
// Drives raster frames of RGB888 pixels through the valid/ready input and
// checks every averaged 2x2 block, with its row and frame end flags, against
// a cycle-free model of the downscaler kept inside the bench. Frame sizes
// change between frames (and the height also inside a frame), and source
// gaps and sink stalls are mixed in by phase.
// ----------------------------------------------------------------------------

module tb;
    import rhd_pkg::*;

    localparam int SETTLE_CYCLES = 8;     // extra wait once no block is pending
    localparam int STALL_LIMIT   = 5000;  // cycles with no transfer at all
    localparam int RANDOM_PIXELS = 1650;
    localparam int MAX_REPORTS   = 10;
    localparam int SINK_HOLD     = 300;

    // One averaged block as it leaves the block
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              row_end;
        logic              frame_end;
    } block_avg_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [CHAN_W-1:0]    red_in;
    logic [CHAN_W-1:0]    green_in;
    logic [CHAN_W-1:0]    blue_in;
    logic                 out_valid;
    logic                 out_ready;
    logic [CHAN_W-1:0]    red_avg;
    logic [CHAN_W-1:0]    green_avg;
    logic [CHAN_W-1:0]    blue_avg;
    logic                 row_end;
    logic                 frame_end;

    rgb_half_downscale_top dut (.*);

    // Model state: size registers, held first pixel, line of pair sums, position
    logic [DIM_W-1:0]  size_width;
    logic [DIM_W-1:0]  size_height;
    logic [23:0]       held_pixel;
    rhd_psum_t         line_sums [LINE_DEPTH];
    int                col_pos;
    int                row_pos;

    block_avg_t        pending_blocks [$];

    int items_sent;
    int blocks_checked;
    int error_count;
    int report_count;
    int size_settings;
    int src_idle_pct;
    int snk_stall_pct;
    int hold_left;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Advance the model by one accepted pixel; queue the block it completes
    function automatic void downscale_pixel(input logic [CHAN_W-1:0] r, g, b);
        int                w;
        int                h;
        int                pair_cols;
        int                pair_rows;
        int                idx;
        logic [PSUM_W-1:0] sr;
        logic [PSUM_W-1:0] sg;
        logic [PSUM_W-1:0] sb;
        logic [QSUM_W-1:0] tr;
        logic [QSUM_W-1:0] tg;
        logic [QSUM_W-1:0] tb_sum;
        block_avg_t        blk;
        w = (size_width == 0) ? 1 : (int'(size_width) > MAX_WIDTH) ? MAX_WIDTH
                                                                  : int'(size_width);
        h = (size_height == 0) ? 1 : (int'(size_height) > MAX_HEIGHT) ? MAX_HEIGHT
                                                                     : int'(size_height);
        pair_cols = (w / 2) * 2;
        pair_rows = (h / 2) * 2;
        if (col_pos < pair_cols && row_pos < pair_rows)
        begin
            if (col_pos % 2 == 0)
                held_pixel = {r, g, b};
            else
            begin
                sr  = r + held_pixel[23:16];
                sg  = g + held_pixel[15:8];
                sb  = b + held_pixel[7:0];
                idx = (col_pos / 2) % LINE_DEPTH;
                if (row_pos % 2 == 0)
                    line_sums[idx] = {sr, sg, sb};
                else
                begin
                    tr            = sr + line_sums[idx].r;
                    tg            = sg + line_sums[idx].g;
                    tb_sum        = sb + line_sums[idx].b;
                    blk.red       = tr[QSUM_W-1:2];
                    blk.green     = tg[QSUM_W-1:2];
                    blk.blue      = tb_sum[QSUM_W-1:2];
                    blk.row_end   = (col_pos + 1 == pair_cols);
                    blk.frame_end = blk.row_end && (row_pos + 1 == pair_rows);
                    pending_blocks.push_back(blk);
                end
            end
        end
        // raster position wraps on the clamped sizes
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
    endfunction

    // Mostly random, with the channel extremes now and then
    function automatic logic [CHAN_W-1:0] rand_channel();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return CHAN_W'($urandom);
        endcase
    endfunction

    // Sink side: long hold-off when asked, else random stalls
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_ready <= 1'b0;
                hold_left--;
            end
            else
                out_ready <= !(snk_stall_pct != 0 && $urandom_range(99) < snk_stall_pct);
        end
    end

    // Result checker: every output transfer against the oldest expected block
    always @(posedge clk)
    begin : check_results
        block_avg_t got;
        block_avg_t want;
        if (rst_n && out_valid && out_ready)
        begin
            got = {red_avg, green_avg, blue_avg, row_end, frame_end};
            if (pending_blocks.size() == 0)
            begin
                error_count++;
                if (report_count < MAX_REPORTS)
                begin
                    report_count++;
                    $display("tb: unexpected block rgb=%02h%02h%02h re=%b fe=%b",
                             got.red, got.green, got.blue, got.row_end, got.frame_end);
                end
            end
            else
            begin
                want = pending_blocks.pop_front();
                blocks_checked++;
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.row_end !== want.row_end ||
                    got.frame_end !== want.frame_end)
                begin
                    error_count++;
                    if (report_count < MAX_REPORTS)
                    begin
                        report_count++;
                        $display("tb: block %0d expected rgb=%02h%02h%02h re=%b fe=%b,",
                                 blocks_checked, want.red, want.green, want.blue,
                                 want.row_end, want.frame_end,
                                 " got rgb=%02h%02h%02h re=%b fe=%b",
                                 got.red, got.green, got.blue,
                                 got.row_end, got.frame_end);
                    end
                end
            end
        end
    end

    // Watchdog: ends the run when nothing moves on either channel
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: no transfer for %0d cycles", STALL_LIMIT);
        $display("tb: done, errors");
        $finish;
    end

    // Send one pixel; called and returns at a falling edge
    task automatic send_pixel(input logic [CHAN_W-1:0] r, g, b);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do
            @(posedge clk);
        while (!in_ready);
        downscale_pixel(r, g, b);
        items_sent++;
        @(negedge clk);
    endtask

    // Random pixels until the raster position is back at the frame start
    task automatic run_to_frame_end();
        do
            send_pixel(rand_channel(), rand_channel(), rand_channel());
        while (col_pos != 0 || row_pos != 0);
    endtask

    // Wait until every expected block has left, then let the pipe settle
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_blocks.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_size_reg(input rhd_cfg_idx_t idx, input logic [DIM_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == CFG_IMAGE_WIDTH)
            size_width = val;
        else
            size_height = val;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_frame_size(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
        drain_results();
        write_size_reg(CFG_IMAGE_WIDTH, w);
        write_size_reg(CFG_IMAGE_HEIGHT, h);
        size_settings++;
    endtask

    task automatic set_idle(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // Full-scale, zero and mixed blocks, smallest frame, odd column and row drop
    task automatic test_block_values();
        logic [23:0] pattern [8];
        pattern = '{24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h010203,
                    24'hFFFFFF, 24'hFFFFFF, 24'h030201, 24'hAA55FE};
        set_idle(0, 0);
        set_frame_size(4, 2);
        foreach (pattern[i])
            send_pixel(pattern[i][23:16], pattern[i][15:8], pattern[i][7:0]);
        set_frame_size(2, 2);
        repeat (4) send_pixel('0, '0, '0);
        set_frame_size(3, 3);
        run_to_frame_end();
    endtask

    // Size registers at and below their lower bound, and sizes with no blocks
    task automatic test_size_limits();
        set_idle(0, 0);
        set_frame_size(12'd1, 12'd4);
        run_to_frame_end();
        set_frame_size(12'd6, 12'd1);
        run_to_frame_end();
        set_frame_size(12'd0, 12'd2);
        run_to_frame_end();
        set_frame_size(12'd4, 12'd0);
        run_to_frame_end();
        set_frame_size(12'd0, 12'd0);
        repeat (3) run_to_frame_end();
    endtask

    // Height rewritten at the start of an even row: shrink, grow, and below position
    task automatic test_height_change_mid_frame();
        set_idle(0, 0);
        set_frame_size(6, 8);
        repeat (12) send_pixel(rand_channel(), rand_channel(), rand_channel());
        drain_results();
        write_size_reg(CFG_IMAGE_HEIGHT, 3);
        run_to_frame_end();
        set_frame_size(4, 4);
        repeat (8) send_pixel(rand_channel(), rand_channel(), rand_channel());
        drain_results();
        write_size_reg(CFG_IMAGE_HEIGHT, 7);
        run_to_frame_end();
        set_frame_size(4, 8);
        repeat (24) send_pixel(rand_channel(), rand_channel(), rand_channel());
        drain_results();
        write_size_reg(CFG_IMAGE_HEIGHT, 4);
        run_to_frame_end();
    endtask

    // Sink holds off while the source keeps offering, so the input stalls
    task automatic test_backpressure();
        set_idle(0, 0);
        set_frame_size(16, 4);
        hold_left = SINK_HOLD;
        repeat (2) run_to_frame_end();
    endtask

    // Random frame sizes and contents, rotating through the idle modes
    task automatic test_random_frames();
        int               start_count;
        int               phase;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        start_count = items_sent;
        phase       = 0;
        while (items_sent - start_count < RANDOM_PIXELS)
        begin
            case (phase % 4)
                0:       set_idle(0, 0);
                1:       set_idle(69, 0);
                2:       set_idle(0, 69);
                default: set_idle(20, 20);
            endcase
            case ($urandom_range(19))
                0:       w = DIM_W'($urandom_range(1));
                1:       w = DIM_W'($urandom_range(21, 40));
                default: w = DIM_W'($urandom_range(2, 20));
            endcase
            if ($urandom_range(19) == 0)
                h = DIM_W'($urandom_range(1));
            else
                h = DIM_W'($urandom_range(2, 8));
            set_frame_size(w, h);
            repeat ($urandom_range(1, 2)) run_to_frame_end();
            phase++;
        end
    endtask

    // Main sequence
    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = CFG_IMAGE_WIDTH;
        cfg_data       = '0;
        in_valid       = 1'b0;
        red_in         = '0;
        green_in       = '0;
        blue_in        = '0;
        size_width     = RESET_W;
        size_height    = RESET_H;
        held_pixel     = '0;
        col_pos        = 0;
        row_pos        = 0;
        items_sent     = 0;
        blocks_checked = 0;
        error_count    = 0;
        report_count   = 0;
        size_settings  = 0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_left      = 0;
        foreach (line_sums[i])
            line_sums[i] = '0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_block_values();
        test_size_limits();
        test_height_change_mid_frame();
        test_backpressure();
        test_random_frames();
        drain_results();

        $display("tb: %0d pixels sent, %0d blocks checked across %0d frame sizes",
                 items_sent, blocks_checked, size_settings);
        $display("tb: covered size clamps, odd sizes, mid-frame height change, sink hold-off");
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

/* files.f */
hw/rtl/rhd_pkg.sv
hw/rtl/rhd_raster_ctrl.sv
hw/rtl/rgb_half_downscale_top.sv
hw/rtl/rhd_checker.sv
tb/tb.sv
